// ===== sv/nal_ue_pkg.sv =====
// Shared types and constants for the NAL unit extractor.
package nal_ue_pkg;

   localparam int MaxRes = 4;

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_NAL  = 2'd1,
      PH_DROP = 2'd2
   } phase_type;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_START = 2'd1;
   localparam logic [1:0] ERR_SHORT    = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       nal_done;
      logic [1:0] error_code;
      logic       run_last;
   } res_word_type;

   typedef struct packed {
      logic [2:0]                        cnt;
      res_word_type [MaxRes-1:0]         words;
   } res_set_type;

endpackage

// ===== sv/nal_ue_core.sv =====
// Start code tracking, look-ahead window and escape removal for one input byte.
module nal_ue_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output nal_ue_pkg::res_set_type  res_set
);

   nal_ue_pkg::phase_type phase_ff, phase_in;
   logic [1:0]            pc_ff, pc_in;
   logic [1:0]            fill_ff, fill_in;
   logic [1:0]            esc_ff, esc_in;
   logic [1:0]            nbc_ff, nbc_in;
   logic [2:0][7:0]       win_ff, win_in;

   logic [3:0][7:0]       rel_v;
   logic [2:0]            rel_cnt;
   logic                  held_zero;
   logic [1:0]            nbc_inc;
   logic                  want_done;
   logic                  clr_esc;
   logic [1:0]            err;
   logic                  ok;
   logic                  found;
   logic [1:0]            esc_v;
   logic [2:0]            n;

   always_comb begin
      phase_in  = phase_ff;
      pc_in     = pc_ff;
      fill_in   = fill_ff;
      nbc_in    = nbc_ff;
      win_in    = win_ff;
      rel_v     = '0;
      rel_cnt   = 3'd0;
      want_done = 1'b0;
      clr_esc   = 1'b0;
      err       = nal_ue_pkg::ERR_NONE;
      ok        = 1'b0;
      found     = 1'b0;
      nbc_inc   = (nbc_ff < 2'd2) ? nbc_ff + 2'd1 : nbc_ff;
      held_zero = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < fill_ff && win_ff[i] != 8'd0) begin
            held_zero = 1'b0;
         end
      end

      case (phase_ff)
         nal_ue_pkg::PH_NAL: begin
            nbc_in = nbc_inc;
            if (in_byte == 8'd1 && held_zero && fill_ff >= 2'd2) begin
               // A start code closes this unit and opens the next one.
               want_done = 1'b1;
               fill_in   = 2'd0;
               clr_esc   = 1'b1;
               nbc_in    = 2'd0;
               if (in_last) begin
                  err      = nal_ue_pkg::ERR_SHORT;
                  phase_in = nal_ue_pkg::PH_SEEK;
                  pc_in    = 2'd0;
               end
            end else if (in_last && nbc_inc < 2'd2) begin
               err      = nal_ue_pkg::ERR_SHORT;
               phase_in = nal_ue_pkg::PH_SEEK;
               pc_in    = 2'd0;
               fill_in  = 2'd0;
               clr_esc  = 1'b1;
               nbc_in   = 2'd0;
            end else begin
               if (in_byte == 8'd0) begin
                  if (!held_zero) begin
                     for (int i = 0; i < 3; i++) begin
                        if (2'(i) < fill_in && rel_cnt < 3'd4) begin
                           rel_v[rel_cnt[1:0]] = win_in[i];
                           rel_cnt = rel_cnt + 3'd1;
                        end
                     end
                     fill_in = 2'd0;
                  end
                  if (fill_in == 2'd3) begin
                     if (rel_cnt < 3'd4) begin
                        rel_v[rel_cnt[1:0]] = win_in[0];
                        rel_cnt = rel_cnt + 3'd1;
                     end
                     win_in[0] = win_in[1];
                     win_in[1] = win_in[2];
                     fill_in   = 2'd2;
                  end
                  win_in[fill_in] = 8'd0;
                  fill_in = fill_in + 2'd1;
               end else if (nbc_inc == 2'd1 && !in_last && fill_in == 2'd0) begin
                  // Hold the first byte after a start code.
                  win_in[0] = in_byte;
                  fill_in   = 2'd1;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < fill_in && rel_cnt < 3'd4) begin
                        rel_v[rel_cnt[1:0]] = win_in[i];
                        rel_cnt = rel_cnt + 3'd1;
                     end
                  end
                  fill_in = 2'd0;
                  if (rel_cnt < 3'd4) begin
                     rel_v[rel_cnt[1:0]] = in_byte;
                     rel_cnt = rel_cnt + 3'd1;
                  end
               end
               if (in_last) begin
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < fill_in && rel_cnt < 3'd4) begin
                        rel_v[rel_cnt[1:0]] = win_in[i];
                        rel_cnt = rel_cnt + 3'd1;
                     end
                  end
                  want_done = 1'b1;
                  phase_in  = nal_ue_pkg::PH_SEEK;
                  pc_in     = 2'd0;
                  fill_in   = 2'd0;
                  clr_esc   = 1'b1;
                  nbc_in    = 2'd0;
               end
            end
         end
         nal_ue_pkg::PH_SEEK: begin
            if (pc_ff < 2'd2) begin
               ok = (in_byte == 8'd0);
            end else if (pc_ff == 2'd2) begin
               found = (in_byte == 8'd1);
               ok    = (in_byte == 8'd0);
            end else begin
               found = (in_byte == 8'd1);
            end
            if (found) begin
               phase_in = nal_ue_pkg::PH_NAL;
               fill_in  = 2'd0;
               clr_esc  = 1'b1;
               nbc_in   = 2'd0;
               if (in_last) begin
                  err      = nal_ue_pkg::ERR_SHORT;
                  phase_in = nal_ue_pkg::PH_SEEK;
                  pc_in    = 2'd0;
               end
            end else if (ok) begin
               pc_in = pc_ff + 2'd1;
               if (in_last) begin
                  err      = nal_ue_pkg::ERR_NO_START;
                  phase_in = nal_ue_pkg::PH_SEEK;
                  pc_in    = 2'd0;
                  fill_in  = 2'd0;
                  clr_esc  = 1'b1;
                  nbc_in   = 2'd0;
               end
            end else begin
               err     = nal_ue_pkg::ERR_NO_START;
               pc_in   = 2'd0;
               fill_in = 2'd0;
               clr_esc = 1'b1;
               nbc_in  = 2'd0;
               phase_in = in_last ? nal_ue_pkg::PH_SEEK : nal_ue_pkg::PH_DROP;
            end
         end
         default: begin
            if (in_last) begin
               phase_in = nal_ue_pkg::PH_SEEK;
               pc_in    = 2'd0;
               fill_in  = 2'd0;
               clr_esc  = 1'b1;
               nbc_in   = 2'd0;
            end
         end
      endcase

      // Released bytes pass the emulation prevention filter in order.
      res_set = '0;
      n       = 3'd0;
      esc_v   = esc_ff;
      for (int j = 0; j < 4; j++) begin
         if (3'(j) < rel_cnt) begin
            if (rel_v[j] == 8'h03 && esc_v == 2'd2) begin
               esc_v = 2'd0;
            end else begin
               if (n < 3'd4) begin
                  res_set.words[n[1:0]].out_byte = rel_v[j];
                  res_set.words[n[1:0]].has_byte = 1'b1;
                  n = n + 3'd1;
               end
               if (rel_v[j] == 8'd0) begin
                  esc_v = (esc_v < 2'd2) ? esc_v + 2'd1 : 2'd2;
               end else begin
                  esc_v = 2'd0;
               end
            end
         end
      end
      if (want_done) begin
         if (n != 3'd0) begin
            res_set.words[2'(n - 3'd1)].nal_done = 1'b1;
         end else begin
            res_set.words[0].nal_done = 1'b1;
            n = 3'd1;
         end
      end
      if (err != nal_ue_pkg::ERR_NONE && n < 3'd4) begin
         res_set.words[n[1:0]].error_code = err;
         n = n + 3'd1;
      end
      if (n != 3'd0) begin
         res_set.words[2'(n - 3'd1)].run_last = 1'b1;
      end
      res_set.cnt = n;
      esc_in = clr_esc ? 2'd0 : esc_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nal_ue_pkg::PH_SEEK;
         pc_ff    <= 2'd0;
         fill_ff  <= 2'd0;
         esc_ff   <= 2'd0;
         nbc_ff   <= 2'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         fill_ff  <= fill_in;
         esc_ff   <= esc_in;
         nbc_ff   <= nbc_in;
      end
   end

   // Held bytes are only read below the fill count, so they need no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== sv/nal_ue_outq.sv =====
// Result register holding the words of one input byte and handing them out one a cycle while rsp_stall is low.
module nal_ue_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_req,
   input  nal_ue_pkg::res_set_type   res_set,
   input  logic                      rsp_stall,
   output logic                      can_load,
   output logic                      rsp_valid,
   output nal_ue_pkg::res_word_type  rsp_word
);

   logic [2:0]                                    cnt_ff, cnt_in;
   nal_ue_pkg::res_word_type [nal_ue_pkg::MaxRes-1:0] words_ff, words_in;
   logic                                          pop;
   logic                                          load;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_word  = words_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign can_load  = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && pop);
   assign load      = load_req && can_load;

   always_comb begin
      cnt_in   = cnt_ff;
      words_in = words_ff;
      if (load) begin
         cnt_in   = res_set.cnt;
         words_in = res_set.words;
      end else if (pop) begin
         cnt_in = cnt_ff - 3'd1;
         for (int i = 0; i < nal_ue_pkg::MaxRes - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(nal_ue_pkg::MaxRes))
      else $error("result count above capacity");

   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 3'd0 || (cnt_ff == 3'd1 && pop)))
      else $error("new words loaded over pending words");

   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd1 |-> words_ff[0].run_last)
      else $error("final pending word lacks run_last");
`endif

endmodule

// ===== sv/nal_unit_extractor.sv =====
// Top level of the Annex B NAL unit extractor with emulation prevention removal.
// A byte accepted is held in the input register until the result register can load,
// and its result words are then presented from the result register.
// Throughput: one byte per cycle while each byte yields at most one word and rsp_stall is low; a
// byte that yields more words (up to 4) holds the input register until they drain through the single result port.
// Reset is synchronous and active high; it clears control state, not the window or other data registers.
module nal_unit_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_nal_done,
   output logic [1:0] rsp_error_code,
   output logic       rsp_run_last
);

   logic                     in_vld_ff, in_vld_in;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic                     can_load;
   logic                     step;
   logic                     accept;
   nal_ue_pkg::res_set_type  res_set;
   nal_ue_pkg::res_word_type rsp_word;

   assign step      = in_vld_ff && can_load;
   assign req_stall = in_vld_ff && !can_load;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept ? 1'b1 : (step ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_buffer_end;
      end
   end

   nal_ue_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .res_set (res_set)
   );

   nal_ue_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load_req  (in_vld_ff),
      .res_set   (res_set),
      .rsp_stall (rsp_stall),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_byte   = rsp_word.out_byte;
   assign rsp_has_byte   = rsp_word.has_byte;
   assign rsp_nal_done   = rsp_word.nal_done;
   assign rsp_error_code = rsp_word.error_code;
   assign rsp_run_last   = rsp_word.run_last;

`ifndef SYNTHESIS
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != nal_ue_pkg::ERR_NONE) |-> (!rsp_has_byte && !rsp_nal_done))
      else $error("error word carries a byte or an end mark");
`endif

endmodule
